[rtl/mbqeq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbqeq_pkg
// Shared constants of the multichannel biquad equaliser: field widths,
// register map and output mix codes.
// ----------------------------------------------------------------------------
package mbqeq_pkg;

    localparam int CH_BITS            = 3;
    localparam int COEF_BITS          = 32;
    localparam int APB_ADDR_BITS      = 5;
    localparam int APB_DATA_BITS      = 32;

    localparam int DEF_NUM_CHANNELS   = 8;
    localparam int DEF_SAMPLE_BITS    = 24;
    localparam int DEF_COEF_FRAC_BITS = 27;

    // register index = paddr[4:2]
    localparam logic [2:0] REG_B0  = 3'd0;
    localparam logic [2:0] REG_B1  = 3'd1;
    localparam logic [2:0] REG_B2  = 3'd2;
    localparam logic [2:0] REG_A1  = 3'd3;
    localparam logic [2:0] REG_A2  = 3'd4;
    localparam logic [2:0] REG_MIX = 3'd5;

    localparam logic [1:0] MIX_Y    = 2'd0;
    localparam logic [1:0] MIX_SUM  = 2'd1;
    localparam logic [1:0] MIX_DIFF = 2'd2;

endpackage

[rtl/multichannel_biquad_equalizer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_biquad_equalizer_core
// Direct form 1 biquad over an interleaved multichannel sample stream, with
// per-channel history held in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_axis (channel + signed sample); one filtered word
//   per input leaves on m_axis in the same order, channel echoed.
//   Coefficients (Q4.27) and the output mix are written over the APB port
//   while the stream is idle.
// Path: a word accepted on s_axis is registered through history read, multiply,
//   partial sums, round and saturate/mix before it shows on m_axis.
// Throughput: one word per cycle while no word names a channel that one of the
//   four internal stages still holds and m_axis does not stall. The history entry
//   of a channel is rewritten only as the word leaves the last stage, so a word of
//   a channel still in the four internal stages waits until that word has left.
// Reset: clears the coefficients to a pass-through (b0 = 1.0, mix = y), empties
//   the pipeline and marks every history entry invalid, which reads as zero.
//   No clearing pass is needed.
// Stall: an output register with a skid stage behind it lets the pipeline
//   advance after m_axis_tready drops until a word reaches the skid stage;
//   the pipeline then holds and s_axis_tready goes low until the skid stage
//   drains.
// ----------------------------------------------------------------------------
module multichannel_biquad_equalizer_core
    import mbqeq_pkg::*;
#(
    parameter int NUM_CHANNELS   = DEF_NUM_CHANNELS,
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    localparam int TDW = ((CH_BITS + SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [TDW-1:0]           s_axis_tdata,  // channel, sample_in, zero pad
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [TDW-1:0]           m_axis_tdata,  // channel_out, sample_out, zero pad
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PW    = COEF_BITS + SB;
    localparam int ACCW  = PW + 3;
    localparam int HW    = 4 * SB;
    localparam int PADW  = TDW - CH_BITS - SB;

    localparam logic [ACCW-1:0] RND_HALF =
        {{(ACCW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic [ACCW-1:0] SAT_MAX = {{(ACCW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic [ACCW-1:0] SAT_MIN = {{(ACCW-SB+1){1'b1}}, {(SB-1){1'b0}}};
    localparam logic [COEF_BITS-1:0] B0_RESET =
        {{(COEF_BITS-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;

    // ---------------------------------------------------------------- config
    logic signed [COEF_BITS-1:0] r_coef_b0, r_coef_b1, r_coef_b2, r_coef_a1, r_coef_a2;
    logic [1:0]                  r_mix;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b0 <= B0_RESET;
            r_coef_b1 <= '0;
            r_coef_b2 <= '0;
            r_coef_a1 <= '0;
            r_coef_a2 <= '0;
            r_mix     <= MIX_Y;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_B0:  r_coef_b0 <= pwdata;
                REG_B1:  r_coef_b1 <= pwdata;
                REG_B2:  r_coef_b2 <= pwdata;
                REG_A1:  r_coef_a1 <= pwdata;
                REG_A2:  r_coef_a2 <= pwdata;
                REG_MIX: r_mix     <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_B0:  prdata = r_coef_b0;
            REG_B1:  prdata = r_coef_b1;
            REG_B2:  prdata = r_coef_b2;
            REG_A1:  prdata = r_coef_a1;
            REG_A2:  prdata = r_coef_a2;
            REG_MIX: prdata = {{(APB_DATA_BITS-2){1'b0}}, r_mix};
            default: prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- input
    logic [CH_BITS-1:0]        in_ch;
    logic signed [SB-1:0]      in_x;
    logic [CH_BITS+AW-1:0]     in_ch_ext;
    logic                      in_inr;
    logic [AW-1:0]             in_addr;
    logic                      en;
    logic                      hazard;
    logic                      s_accept;

    assign in_ch     = s_axis_tdata[CH_BITS-1:0];
    assign in_x      = s_axis_tdata[CH_BITS+SB-1:CH_BITS];
    assign in_ch_ext = {{AW{1'b0}}, in_ch};
    assign in_inr    = (32'(in_ch) < NUM_CHANNELS);
    // out-of-range channels read entry zero and ignore it
    assign in_addr   = in_inr ? in_ch_ext[AW-1:0] : '0;

    // ---------------------------------------------------------------- stages
    logic                  r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic                  r_s1_inr, r_s2_inr, r_s3_inr, r_s4_inr;
    logic [AW-1:0]         r_s1_addr, r_s2_addr, r_s3_addr, r_s4_addr;
    logic [CH_BITS-1:0]    r_s1_ch, r_s2_ch, r_s3_ch, r_s4_ch;
    logic signed [SB-1:0]  r_s1_x, r_s2_x, r_s3_x, r_s4_x;
    logic signed [SB-1:0]  r_s2_x1, r_s3_x1, r_s4_x1;
    logic signed [SB-1:0]  r_s2_y1, r_s3_y1, r_s4_y1;
    logic signed [PW-1:0]  r_s2_p0, r_s2_p1, r_s2_p2, r_s2_p3, r_s2_p4;
    logic signed [ACCW-1:0] r_s3_ff, r_s3_fb;
    logic signed [ACCW-1:0] r_s4_acc;

    // history memory, entry = {y2, y1, x2, x1}
    logic [HW-1:0]            r_hist_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]  r_hist_vld;
    logic [HW-1:0]            r_rd_data;
    logic                     r_rd_hv;
    logic                     wr_en;
    logic [HW-1:0]            wr_data;

    // stall a word whose channel has not yet been written back
    assign hazard = in_inr && (
        (r_s1_vld && r_s1_inr && (r_s1_addr == in_addr)) ||
        (r_s2_vld && r_s2_inr && (r_s2_addr == in_addr)) ||
        (r_s3_vld && r_s3_inr && (r_s3_addr == in_addr)) ||
        (r_s4_vld && r_s4_inr && (r_s4_addr == in_addr)));

    logic r_skid_vld;
    assign en            = !r_skid_vld;
    assign s_axis_tready = en && !hazard;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= s_accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
        end else if (wr_en) begin
            r_hist_vld[r_s4_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd_data <= r_hist_mem[in_addr];
            r_rd_hv   <= r_hist_vld[in_addr];
        end
        if (wr_en) begin
            r_hist_mem[r_s4_addr] <= wr_data;
        end
    end

    // stage 1: history arrives, multiply
    logic [HW-1:0]        hist;
    logic signed [SB-1:0] h_x1, h_x2, h_y1, h_y2;

    assign hist = (r_s1_inr && r_rd_hv) ? r_rd_data : '0;
    assign h_x1 = hist[SB-1:0];
    assign h_x2 = hist[2*SB-1:SB];
    assign h_y1 = hist[3*SB-1:2*SB];
    assign h_y2 = hist[4*SB-1:3*SB];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ch   <= in_ch;
            r_s1_x    <= in_x;
            r_s1_inr  <= in_inr;
            r_s1_addr <= in_addr;

            r_s2_ch   <= r_s1_ch;
            r_s2_x    <= r_s1_x;
            r_s2_inr  <= r_s1_inr;
            r_s2_addr <= r_s1_addr;
            r_s2_x1   <= h_x1;
            r_s2_y1   <= h_y1;
            r_s2_p0   <= PW'(r_coef_b0) * PW'(r_s1_x);
            r_s2_p1   <= PW'(r_coef_b1) * PW'(h_x1);
            r_s2_p2   <= PW'(r_coef_b2) * PW'(h_x2);
            r_s2_p3   <= PW'(r_coef_a1) * PW'(h_y1);
            r_s2_p4   <= PW'(r_coef_a2) * PW'(h_y2);

            r_s3_ch   <= r_s2_ch;
            r_s3_x    <= r_s2_x;
            r_s3_inr  <= r_s2_inr;
            r_s3_addr <= r_s2_addr;
            r_s3_x1   <= r_s2_x1;
            r_s3_y1   <= r_s2_y1;
            r_s3_ff   <= ACCW'(r_s2_p0) + ACCW'(r_s2_p1) + ACCW'(r_s2_p2);
            r_s3_fb   <= ACCW'(r_s2_p3) + ACCW'(r_s2_p4);

            r_s4_ch   <= r_s3_ch;
            r_s4_x    <= r_s3_x;
            r_s4_inr  <= r_s3_inr;
            r_s4_addr <= r_s3_addr;
            r_s4_x1   <= r_s3_x1;
            r_s4_y1   <= r_s3_y1;
            r_s4_acc  <= r_s3_ff - r_s3_fb + $signed(RND_HALF);
        end
    end

    // stage 4: scale, saturate, mix, write back
    logic signed [ACCW-1:0] acc_sh;
    logic signed [SB-1:0]   y;
    logic [SB:0]            mix_sum, mix_diff;
    logic [SB-1:0]          n_res;
    logic                   s4_go;

    assign acc_sh = r_s4_acc >>> COEF_FRAC_BITS;

    always_comb begin
        if (acc_sh > $signed(SAT_MAX)) begin
            y = SAT_MAX[SB-1:0];
        end else if (acc_sh < $signed(SAT_MIN)) begin
            y = SAT_MIN[SB-1:0];
        end else begin
            y = acc_sh[SB-1:0];
        end
    end

    assign mix_sum  = {r_s4_x[SB-1], r_s4_x} + {y[SB-1], y};
    assign mix_diff = {r_s4_x[SB-1], r_s4_x} - {y[SB-1], y};

    always_comb begin
        case (r_mix)
            MIX_SUM:  n_res = mix_sum[SB:1];
            MIX_DIFF: n_res = mix_diff[SB:1];
            default:  n_res = y;
        endcase
    end

    assign s4_go   = en && r_s4_vld;
    assign wr_en   = s4_go && r_s4_inr;
    assign wr_data = {r_s4_y1, y, r_s4_x1, r_s4_x};

    // ---------------------------------------------------------------- output
    logic                 r_out_vld;
    logic [CH_BITS-1:0]   r_out_ch, r_skid_ch;
    logic [SB-1:0]        r_out_res, r_skid_res;
    logic                 out_load;

    assign out_load = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld  <= r_skid_vld || s4_go;
            r_skid_vld <= 1'b0;
        end else if (s4_go) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_skid_vld) begin
                r_out_ch  <= r_skid_ch;
                r_out_res <= r_skid_res;
            end else begin
                r_out_ch  <= r_s4_ch;
                r_out_res <= n_res;
            end
        end else if (s4_go) begin
            // hold the word behind the stalled output register
            r_skid_ch  <= r_s4_ch;
            r_skid_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{PADW{1'b0}}, r_out_res, r_out_ch};

    // ---------------------------------------------------------------- checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid stage full with output register empty");

    a_no_accept_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> !s_accept)
        else $error("word accepted while skid stage full");

    a_one_per_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_inr) |-> !(
            (r_s2_vld && r_s2_inr && (r_s2_addr == r_s1_addr)) ||
            (r_s3_vld && r_s3_inr && (r_s3_addr == r_s1_addr)) ||
            (r_s4_vld && r_s4_inr && (r_s4_addr == r_s1_addr))))
        else $error("two words of one channel in flight");

    a_wb_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_hist_vld[$past(r_s4_addr)])
        else $error("history write left entry invalid");

endmodule
